@@ rtl/phxd_pkg.sv @@
// Shared types, constants and key bytes for the packet header XOR chain deframer.
// No dependencies; imported by every module of the block.
package phxd_pkg;

  localparam int MAX_BUFFER = 2048;
  localparam int KEY_LEN    = 32;
  localparam int KEY_IDX_W  = $clog2(KEY_LEN);
  localparam int POS_W      = $clog2(MAX_BUFFER) + 1;
  localparam int LEN_W      = 16;
  localparam int CMP_W      = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

  localparam logic [7:0] HDR_SHORT_A = 8'hC1;
  localparam logic [7:0] HDR_SHORT_B = 8'hC3;
  localparam logic [7:0] HDR_LONG_A  = 8'hC2;
  localparam logic [7:0] HDR_LONG_B  = 8'hC4;

  localparam int START_SHORT = 3;
  localparam int START_LONG  = 4;

  localparam logic [7:0] KEY_BYTES [KEY_LEN] = '{
    8'hAB, 8'h11, 8'hCD, 8'hFE, 8'h18, 8'h23, 8'hC5, 8'hA3,
    8'hCA, 8'h33, 8'hC1, 8'hCC, 8'h66, 8'h67, 8'h21, 8'hF3,
    8'h32, 8'h12, 8'h15, 8'h35, 8'h29, 8'hFF, 8'hFE, 8'h1D,
    8'h44, 8'hEF, 8'hCD, 8'h41, 8'h26, 8'h3C, 8'h4E, 8'h4D
  };

  typedef enum logic [1:0] {
    FORM_NONE  = 2'd0,
    FORM_SHORT = 2'd1,
    FORM_LONG  = 2'd2,
    FORM_BAD   = 2'd3
  } form_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_HDR = 2'd1,
    STAT_SHORT   = 2'd2,
    STAT_BAD_LEN = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  typedef struct packed {
    status_e    status;
    logic       done;
    logic       keep;
    logic [7:0] data;
  } out_word_t;

endpackage

@@ rtl/phxd_in_stage.sv @@
// Input register of the deframer: captures one stream word.
// Depends on phxd_pkg.
module phxd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  phxd_pkg::in_word_t word_i,
  input  logic              advance_i,
  output logic              valid_o,
  output phxd_pkg::in_word_t word_o
);
  import phxd_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     load;

  assign s_axis_tready = !valid_q || advance_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

@@ rtl/phxd_step.sv @@
// Frame state and per-byte logic: header decode, XOR chain, keep and status.
// Depends on phxd_pkg.
module phxd_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  phxd_pkg::in_word_t  word_i,
  output phxd_pkg::out_word_t res_o
);
  import phxd_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  form_e            form_q, form_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       prev_q, prev_d;

  logic [CMP_W-1:0] p_ext, len_ext, start;
  logic             valid, chain, keep;
  logic [7:0]       b, o;
  status_e          status;

  assign b       = word_i.data;
  assign p_ext   = CMP_W'(pos_q);

  always_comb begin
    form_d = form_q;
    len_d  = len_q;
    if (pos_q == '0) begin
      if (b == HDR_SHORT_A || b == HDR_SHORT_B) begin
        form_d = FORM_SHORT;
      end else if (b == HDR_LONG_A || b == HDR_LONG_B) begin
        form_d = FORM_LONG;
      end else begin
        form_d = FORM_BAD;
      end
      len_d = '0;
    end else if (pos_q == POS_W'(1) && form_q == FORM_SHORT) begin
      len_d = LEN_W'(b);
    end else if (pos_q == POS_W'(1) && form_q == FORM_LONG) begin
      len_d = {b, 8'h00};
    end else if (pos_q == POS_W'(2) && form_q == FORM_LONG) begin
      len_d = {len_q[LEN_W-1:8], b};
    end
  end

  assign len_ext = CMP_W'(len_d);
  assign valid   = (form_d == FORM_SHORT) || (form_d == FORM_LONG);
  assign start   = (form_d == FORM_SHORT) ? CMP_W'(START_SHORT) : CMP_W'(START_LONG);
  assign chain   = valid && (p_ext >= start) && (p_ext < len_ext);
  assign o       = chain ? (b ^ prev_q ^ KEY_BYTES[pos_q[KEY_IDX_W-1:0]]) : b;

  always_comb begin
    if (!valid) begin
      keep = 1'b0;
    end else if (pos_q == '0 || (pos_q == POS_W'(1) && form_d == FORM_LONG)) begin
      keep = 1'b1;
    end else begin
      keep = p_ext < len_ext;
    end
  end

  always_comb begin
    status = STAT_OK;
    if (word_i.last) begin
      if (p_ext >= CMP_W'(MAX_BUFFER - 1)) begin
        status = STAT_BAD_LEN;
      end else if (!valid) begin
        status = STAT_BAD_HDR;
      end else if (p_ext + CMP_W'(1) < len_ext) begin
        status = STAT_SHORT;
      end
    end
  end

  always_comb begin
    pos_d  = (pos_q < POS_W'(MAX_BUFFER)) ? pos_q + POS_W'(1) : pos_q;
    prev_d = o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      form_q <= FORM_NONE;
      len_q  <= '0;
      prev_q <= '0;
    end else if (advance_i) begin
      if (word_i.last) begin
        pos_q  <= '0;
        form_q <= FORM_NONE;
        len_q  <= '0;
        prev_q <= '0;
      end else begin
        pos_q  <= pos_d;
        form_q <= form_d;
        len_q  <= len_d;
        prev_q <= prev_d;
      end
    end
  end

  assign res_o.data   = o;
  assign res_o.keep   = keep;
  assign res_o.done   = word_i.last;
  assign res_o.status = status;

endmodule

@@ rtl/phxd_out_stage.sv @@
// Result register of the deframer: holds one output word until taken.
// Depends on phxd_pkg.
module phxd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  phxd_pkg::out_word_t word_i,
  output logic                space_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output phxd_pkg::out_word_t word_o
);
  import phxd_pkg::*;

  logic      valid_q, valid_d;
  out_word_t word_q;

  assign space_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign word_o        = word_q;

endmodule

@@ rtl/packet_header_xor_chain_deframer_core.sv @@
// Top level of the packet header XOR chain deframer.
// Depends on phxd_pkg, phxd_in_stage, phxd_step and phxd_out_stage.
//
// Takes one buffer byte per word (tlast on the final byte) and returns one word per byte,
// at a sustained rate of one word per cycle when neither side stalls, through the input register
// and then the result register. The byte is decoded and XOR-chained against the previous
// output byte combinationally between the two registers; that feedback of the previous
// output byte and the frame state sets the rate. Both sides may stall freely. The first
// byte picks the header form, bytes inside the declared length past the header are
// chained with a 32-byte position key, and the word carrying tlast reports the frame
// status in tuser and returns the block to its start-of-frame state.
module packet_header_xor_chain_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // done_res
  output logic [2:0] m_axis_tuser    // [0] keep, [2:1] status
);
  import phxd_pkg::*;

  in_word_t  in_word, s1_word;
  out_word_t res_word, out_word;
  logic      s1_valid, out_space, advance;

  assign in_word.data = s_axis_tdata;
  assign in_word.last = s_axis_tlast;
  assign advance      = s1_valid && out_space;

  phxd_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .word_i        (in_word),
    .advance_i     (advance),
    .valid_o       (s1_valid),
    .word_o        (s1_word)
  );

  phxd_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .word_i    (s1_word),
    .res_o     (res_word)
  );

  phxd_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .word_i        (res_word),
    .space_o       (out_space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .word_o        (out_word)
  );

  assign m_axis_tdata = out_word.data;
  assign m_axis_tlast = out_word.done;
  assign m_axis_tuser = {out_word.status, out_word.keep};

endmodule

@@ rtl/phxd_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
// Depends on phxd_pkg and packet_header_xor_chain_deframer_core.
module phxd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [2:0] m_axis_tuser
);
  import phxd_pkg::*;

  // a stalled result word holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // status only reported on the final word of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[2:1] == STAT_OK)
    else $error("status set on a word that is not last");

  // a bad header frame never keeps bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2:1] == STAT_BAD_HDR |-> !m_axis_tuser[0])
    else $error("keep set on a bad header frame");

  // with the result side stalled and full, no new word can pass the input register twice
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && s_axis_tvalid && s_axis_tready |=>
      !s_axis_tready || m_axis_tready)
    else $error("input accepted beyond buffer space");

endmodule

bind packet_header_xor_chain_deframer_core phxd_checker u_phxd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
